>>> sv/alsid_pkg.sv
// Shared types and constants for the array list with shift insert and delete.
`default_nettype none
package alsid_pkg;

   localparam int OPCODE_W = 3;
   localparam int POS_W    = 5;
   localparam int VAL_W    = 64;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT   = 3'd0,
      OP_DELETE   = 3'd1,
      OP_LOCATE   = 3'd2,
      OP_RETRIEVE = 3'd3,
      OP_CLEAR    = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage
`default_nettype wire

>>> sv/alsid_ifs.sv
// Request and response channel interfaces of the array list.
`default_nettype none
interface alsid_req_if;
   import alsid_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [POS_W-1:0]    position;
   logic [VAL_W-1:0]    entry_value;

   modport source (output valid, opcode, position, entry_value, input ready);
   modport sink   (input valid, opcode, position, entry_value, output ready);
endinterface

interface alsid_rsp_if;
   import alsid_pkg::*;

   logic                valid;
   logic                ready;
   logic [POS_W-1:0]    result_position;
   logic [VAL_W-1:0]    result_value;
   logic [COUNT_W-1:0]  entry_count;
   logic [STATUS_W-1:0] status;

   modport source (output valid, result_position, result_value, entry_count, status,
                   input ready);
   modport sink   (input valid, result_position, result_value, entry_count, status,
                   output ready);
endinterface
`default_nettype wire

>>> sv/array_list_shift_insert_delete.sv
// Top level of the array list: request register, one pass of list logic, response register.
//
//   channel   | dir | handshake         | payload
//   req_chan  | in  | valid/ready       | opcode, position, entry_value
//   rsp_chan  | out | valid/ready       | result_position, result_value, entry_count, status
//
// One transaction per cycle is accepted unless the response stalls.
// The whole operation, shifts and the parallel compare of locate included, is one
// combinational pass from the request register into the entry array and response register.
// The list is empty after reset; the entry array itself is not cleared.
// A stalled response holds the request register, and the request side fills behind it.
`default_nettype none
module array_list_shift_insert_delete #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   alsid_req_if.sink   req_chan,
   alsid_rsp_if.source rsp_chan
);
   import alsid_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int IDX_W = $clog2(DEPTH);

   // Request register.
   logic                   req_valid_ff, req_valid_in;
   logic [OPCODE_W-1:0]    op_ff;
   logic [POS_W-1:0]       pos_ff;
   logic [VALUE_WIDTH-1:0] val_ff;

   // List state.
   logic [VALUE_WIDTH-1:0] entries_ff [DEPTH];
   logic [VALUE_WIDTH-1:0] entries_in [DEPTH];
   logic [CNT_W-1:0]       count_ff, count_in;

   // Response register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]       rpos_ff, rpos_in;
   logic [VALUE_WIDTH-1:0] rval_ff, rval_in;
   logic [COUNT_W-1:0]     rcount_ff, rcount_in;
   logic [STATUS_W-1:0]    status_ff, status_in;

   logic             rsp_free;
   logic             fire;
   logic             req_take;
   logic             full;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] count_ext;
   logic             insert_ok;
   logic             index_ok;
   logic             found;
   logic [CMP_W-1:0] found_idx;

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign fire     = req_valid_ff && rsp_free;
   assign req_chan.ready = !req_valid_ff || rsp_free;
   assign req_take = req_chan.valid && req_chan.ready;

   assign pos_ext   = CMP_W'(pos_ff);
   assign count_ext = CMP_W'(count_ff);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign insert_ok = !full && (pos_ext <= count_ext);
   assign index_ok  = pos_ext < count_ext;

   // First matching entry below the count; the lowest index wins.
   always_comb begin
      found     = 1'b0;
      found_idx = count_ext;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if ((CMP_W'(i) < count_ext) && (entries_ff[i] == val_ff)) begin
            found     = 1'b1;
            found_idx = CMP_W'(i);
         end
      end
   end

   always_comb begin
      entries_in   = entries_ff;
      count_in     = count_ff;
      req_valid_in = req_take ? 1'b1 : (fire ? 1'b0 : req_valid_ff);
      rsp_valid_in = fire ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
      rpos_in      = pos_ff;
      rval_in      = '0;
      status_in    = ST_OK;
      unique case (op_ff)
         OP_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else if (!insert_ok) begin
               status_in = ST_RANGE;
            end else begin
               // Entries at and above the position move up by one.
               for (int i = 0; i < DEPTH; i++) begin
                  if (CMP_W'(i) == pos_ext) begin
                     entries_in[i] = val_ff;
                  end else if (CMP_W'(i) > pos_ext) begin
                     entries_in[i] = entries_ff[(i == 0) ? 0 : i - 1];
                  end
               end
               count_in = count_ff + 1'b1;
            end
         end
         OP_DELETE: begin
            if (!index_ok) begin
               status_in = ST_RANGE;
            end else begin
               // Entries above the position move down by one.
               for (int i = 0; i < DEPTH - 1; i++) begin
                  if (CMP_W'(i) >= pos_ext) begin
                     entries_in[i] = entries_ff[i + 1];
                  end
               end
               count_in = count_ff - 1'b1;
            end
         end
         OP_LOCATE: begin
            rpos_in = found ? found_idx[POS_W-1:0] : count_ext[POS_W-1:0];
         end
         OP_RETRIEVE: begin
            if (!index_ok) begin
               status_in = ST_RANGE;
            end else begin
               rval_in = entries_ff[pos_ext[IDX_W-1:0]];
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
      rcount_in = CMP_W'(count_in) <= CMP_W'(DEPTH) ? COUNT_W'(CMP_W'(count_in)) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff  <= req_chan.opcode;
         pos_ff <= req_chan.position;
         val_ff <= req_chan.entry_value[VALUE_WIDTH-1:0];
      end
      if (fire) begin
         entries_ff <= entries_in;
         rpos_ff    <= rpos_in;
         rval_ff    <= rval_in;
         rcount_ff  <= rcount_in;
         status_ff  <= status_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.result_position = rpos_ff;
   assign rsp_chan.result_value    = VAL_W'(rval_ff);
   assign rsp_chan.entry_count     = rcount_ff;
   assign rsp_chan.status          = status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(DEPTH))
      else $error("entry count exceeds list depth");

   a_no_fire_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !fire)
      else $error("operation executed while response was stalled");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (fire && (op_ff == OP_INSERT) && insert_ok) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("accepted insert did not grow the list by one");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (fire && (status_in == ST_FULL)) |-> full)
      else $error("full status reported on a list that is not full");

   a_reject_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (fire && (status_in != ST_OK)) |=> $stable(count_ff))
      else $error("rejected transaction changed the entry count");
`endif

endmodule
`default_nettype wire
